### rtl/core/xcfr_pkg.sv
package xcfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;

  // frame_status codes
  localparam logic [1:0] StatusGood     = 2'd0;
  localparam logic [1:0] StatusXorBad   = 2'd1;
  localparam logic [1:0] StatusNoEnd    = 2'd2;
  localparam logic [1:0] StatusTooShort = 2'd3;

  // configuration register indexes
  localparam logic CfgStartMarker = 1'b0;
  localparam logic CfgEndMarker   = 1'b1;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'h01;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'h03;

  localparam logic [ByteW-1:0] SearchLen  = 8'h0F;
  localparam logic [ByteW-1:0] SearchData = 8'h3E;
  localparam logic [PosW-1:0]  MinSize    = 9'd10;
  localparam logic [PosW-1:0]  FirstData  = 9'd7;
  localparam logic [PosW-1:0]  HeadBytes  = 9'd9;

  typedef struct packed {
    logic             is_end;
    logic [ByteW-1:0] payload_byte;
    logic [1:0]       frame_status;
    logic [ByteW-1:0] box_address;
    logic [ByteW-1:0] device_address;
    logic [ByteW-1:0] sequence_count;
    logic [ByteW-1:0] payload_count;
  } xcfr_item_t;

endpackage

### rtl/core/xor_checked_frame_receiver.sv
// Frame receiver for start/length/addresses/data/end-marker/check-byte frames
// guarded by an XOR block check. Feed it one received byte per transaction;
// it hunts for the start marker, reads the length byte (frame size is length
// plus 1, sizes under 10 are reported at once as too short), latches the box
// and device addresses from frame bytes 2 and 3, and passes data bytes from
// offset 7 onward out as they arrive (is_end_o low). The final byte closes
// the frame with one end transaction (is_end_o high) carrying the status,
// the addresses, the reply sequence count and the data byte count. Bad
// frames are flagged in the status, never withheld. The block takes one
// byte per clock cycle sustained while the result side keeps up; a byte
// sits in the input register while the single-pass decoder works on it,
// and its result is then loaded into the output register. A stalled
// result holds the input register, which then stalls the input. The start
// and end marker registers may be rewritten only while the block is idle.
module xor_checked_frame_receiver import xcfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  // received byte channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             is_end_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic [1:0]       frame_status_o,
  output logic [ByteW-1:0] box_address_o,
  output logic [ByteW-1:0] device_address_o,
  output logic [ByteW-1:0] sequence_count_o,
  output logic [ByteW-1:0] payload_count_o
);

  logic [ByteW-1:0] start_marker_q;
  logic [ByteW-1:0] end_marker_q;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;

  logic             out_valid_q, out_valid_d;
  xcfr_item_t       out_item_q;

  logic             in_accept;
  logic             advance;
  logic             item_valid;
  xcfr_item_t       item;

  // Marker registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      end_marker_q   <= EndMarkerRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStartMarker: start_marker_q <= cfg_wdata_i;
        CfgEndMarker:   end_marker_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The held byte advances whenever the output register is free or being
  // drained this cycle; bytes that produce nothing advance as well.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame state and single-pass decode of the held byte.
  xcfr_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte_q),
    .start_marker_i (start_marker_q),
    .end_marker_i   (end_marker_q),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  // Output register: load a new result, otherwise hold until taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && item_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_valid) begin
      out_item_q <= item;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_end_o         = out_item_q.is_end;
  assign payload_byte_o   = out_item_q.payload_byte;
  assign frame_status_o   = out_item_q.frame_status;
  assign box_address_o    = out_item_q.box_address;
  assign device_address_o = out_item_q.device_address;
  assign sequence_count_o = out_item_q.sequence_count;
  assign payload_count_o  = out_item_q.payload_count;

endmodule

### rtl/core/xcfr_parse.sv
module xcfr_parse import xcfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] start_marker_i,
  input  logic [ByteW-1:0] end_marker_i,
  output logic             item_valid_o,
  output xcfr_item_t       item_o
);

  localparam logic PhHunt  = 1'b0;
  localparam logic PhFrame = 1'b1;

  logic             phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  size_q, size_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] prev_q, prev_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] box_q, box_d;
  logic [ByteW-1:0] dev_q, dev_d;
  logic [ByteW-1:0] seq_q, seq_d;

  logic [PosW-1:0] size_eff;
  logic [PosW:0]   pos_p1;
  logic [PosW:0]   pos_p2;
  logic [PosW-1:0] count_full;
  logic [1:0]      status;

  always_comb begin
    size_eff   = (pos_q == PosW'(1)) ? ({1'b0, byte_i} + PosW'(1)) : size_q;
    pos_p1     = {1'b0, pos_q} + (PosW+1)'(1);
    pos_p2     = {1'b0, pos_q} + (PosW+1)'(2);
    count_full = size_eff - HeadBytes;

    if (prev_q != end_marker_i) begin
      status = StatusNoEnd;
    end else if (xor_q != byte_i) begin
      status = StatusXorBad;
    end else begin
      status = StatusGood;
    end

    phase_d = phase_q;
    pos_d   = pos_q;
    size_d  = size_q;
    xor_d   = xor_q;
    prev_d  = prev_q;
    len_d   = len_q;
    first_d = first_q;
    box_d   = box_q;
    dev_d   = dev_q;
    seq_d   = seq_q;

    item_valid_o = 1'b0;
    item_o       = '0;

    if (phase_q == PhHunt) begin
      // drop bytes until the opening marker
      if (byte_i == start_marker_i) begin
        phase_d = PhFrame;
        pos_d   = PosW'(1);
        xor_d   = byte_i;
        prev_d  = byte_i;
      end
    end else if (pos_q == PosW'(1) && size_eff < MinSize) begin
      len_d                 = byte_i;
      size_d                = size_eff;
      item_valid_o          = 1'b1;
      item_o.is_end         = 1'b1;
      item_o.frame_status   = StatusTooShort;
      item_o.sequence_count = seq_q;
      phase_d               = PhHunt;
      pos_d                 = '0;
    end else begin
      if (pos_q == PosW'(1)) begin
        len_d  = byte_i;
        size_d = size_eff;
      end
      if (pos_q == PosW'(2)) begin
        box_d = byte_i;
      end
      if (pos_q == PosW'(3)) begin
        dev_d = byte_i;
      end

      if (pos_p1 >= {1'b0, size_eff}) begin
        // block check byte closes the frame
        if (status == StatusGood) begin
          if (len_q == SearchLen && first_q == SearchData) begin
            seq_d = '0;
          end else begin
            seq_d = seq_q + ByteW'(1);
          end
        end
        item_valid_o          = 1'b1;
        item_o.is_end         = 1'b1;
        item_o.frame_status   = status;
        item_o.box_address    = box_q;
        item_o.device_address = dev_q;
        item_o.sequence_count = seq_d;
        item_o.payload_count  = count_full[ByteW-1:0];
        phase_d               = PhHunt;
        pos_d                 = '0;
      end else begin
        if (pos_q >= FirstData && pos_p2 < {1'b0, size_eff}) begin
          if (pos_q == FirstData) begin
            first_d = byte_i;
          end
          item_valid_o        = 1'b1;
          item_o.payload_byte = byte_i;
        end
        xor_d  = xor_q ^ byte_i;
        prev_d = byte_i;
        pos_d  = pos_p1[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      pos_q   <= '0;
      size_q  <= '0;
      xor_q   <= '0;
      prev_q  <= '0;
      len_q   <= '0;
      first_q <= '0;
      box_q   <= '0;
      dev_q   <= '0;
      seq_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      size_q  <= size_d;
      xor_q   <= xor_d;
      prev_q  <= prev_d;
      len_q   <= len_d;
      first_q <= first_d;
      box_q   <= box_d;
      dev_q   <= dev_d;
      seq_q   <= seq_d;
    end
  end

endmodule

### rtl/core/xcfr_checker.sv
module xcfr_checker import xcfr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             is_end_o,
  input logic [ByteW-1:0] payload_byte_o,
  input logic [1:0]       frame_status_o,
  input logic [ByteW-1:0] box_address_o,
  input logic [ByteW-1:0] device_address_o,
  input logic [ByteW-1:0] sequence_count_o,
  input logic [ByteW-1:0] payload_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_end_o)
      && $stable(payload_byte_o) && $stable(frame_status_o))
    else $error("result changed while stalled");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_end_o |-> frame_status_o == StatusGood
      && box_address_o == '0 && device_address_o == '0
      && sequence_count_o == '0 && payload_count_o == '0)
    else $error("data item carries end fields");

  a_short_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_end_o && frame_status_o == StatusTooShort
      |-> box_address_o == '0 && device_address_o == '0
        && payload_count_o == '0 && payload_byte_o == '0)
    else $error("too-short report carries frame fields");

  a_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_end_o && frame_status_o != StatusTooShort
      |-> payload_count_o != '0 && payload_byte_o == '0)
    else $error("frame end without data count");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_valid_i) |=> !out_valid_o || $past(in_stall_o)
      || $past(out_valid_o) || $past(in_valid_i, 2))
    else $error("result appeared without input");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (.*);
